// ===== sv/ghlt_pkg.sv =====
// Shared types, constants and helpers of the handle lease table.
`default_nettype none
package ghlt_pkg;
  localparam int OBJECT_SLOTS  = 64;
  localparam int LEASE_SLOTS   = 16;
  localparam int PROJECT_LIMIT = 4;

  localparam int OBJ_AW = $clog2(OBJECT_SLOTS);
  localparam int OBJ_CW = $clog2(OBJECT_SLOTS + 1);
  localparam int LS_AW  = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
  localparam int LS_CW  = $clog2(LEASE_SLOTS + 1);
  localparam int PT_W   = $clog2(PROJECT_LIMIT + 1);

  localparam int ID_W   = 32;
  localparam int KIND_W = 3;
  localparam int LGEN_W = 31;
  localparam int SLOT_W = 8;
  localparam int TAG_W  = 4;
  localparam int HDL_W  = 43;
  localparam int ST_W   = 3;

  localparam logic [TAG_W-1:0]  TAG_VALUE     = 4'hA;
  localparam logic [LGEN_W-1:0] LEASE_GEN_MAX = 31'h7fffffff;
  localparam logic [ID_W-1:0]   GEN_MAX       = 32'hffffffff;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD       = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_STALE     = 3'd3;
  localparam logic [ST_W-1:0] ST_MISMATCH  = 3'd4;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd5;

  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PROJECT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ITEM    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FOLDER  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FOOTAGE = 3'd4;

  typedef enum logic [1:0] {
    CMD_REGISTER, CMD_BORROW, CMD_RESOLVE, CMD_INVALIDATE
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   proj;
    logic [ID_W-1:0]   obj;
    logic [ID_W-1:0]   gen;
    logic [KIND_W-1:0] kind;
  } ident_t;

  typedef struct packed {
    logic [LGEN_W-1:0] lgen;
    ident_t            target;
  } lease_entry_t;

  typedef struct packed {
    logic             ok;
    logic [ST_W-1:0]  status;
    logic [HDL_W-1:0] handle;
    ident_t           id;
  } res_t;

  function automatic logic is_item_group(logic [KIND_W-1:0] k);
    return k == KIND_ITEM || k == KIND_FOLDER || k == KIND_FOOTAGE;
  endfunction

  function automatic res_t mk_res(logic [ST_W-1:0] st, logic [HDL_W-1:0] h, ident_t id);
    res_t r;
    r.ok     = (st == ST_OK);
    r.status = st;
    r.handle = (st == ST_OK) ? h : '0;
    r.id     = (st == ST_OK) ? id : '0;
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== sv/generational_handle_lease_table.sv =====
// Top level: request sequencer over the object and lease memories.
//
// channel  | direction | handshake          | fields
// request  | in        | start & !busy      | cmd, ids, generation, kind, handle, filters
// result   | out       | done (one cycle)   | ok, status, handle_out, identity
//
// From acceptance to the result, the time a request takes is set by the one-entry-per-cycle
// scans of the object memory and the lease memory.
// Register scans the filled objects, borrow and invalidate add lease scans.
// Synchronous reset clears counts and lease flags at once; no clearing pass.
// busy is high from acceptance until the cycle done pulses, but a request refused
// at acceptance never raises it; results are not stalled.
`default_nettype none
module generational_handle_lease_table (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             cmd,
  input  wire logic [ghlt_pkg::ID_W-1:0]   proj_num,
  input  wire logic [ghlt_pkg::ID_W-1:0]   obj_num,
  input  wire logic [ghlt_pkg::ID_W-1:0]   generation,
  input  wire logic [ghlt_pkg::KIND_W-1:0] object_kind,
  input  wire logic [ghlt_pkg::HDL_W-1:0]  handle,
  input  wire logic                   kind_group,
  input  wire logic [ghlt_pkg::ID_W-1:0]   required_project,
  output logic                        done,
  output logic                        ok,
  output logic [ghlt_pkg::ST_W-1:0]   status,
  output logic [ghlt_pkg::HDL_W-1:0]  handle_out,
  output logic [ghlt_pkg::ID_W-1:0]   proj_num_out,
  output logic [ghlt_pkg::ID_W-1:0]   obj_num_out,
  output logic [ghlt_pkg::ID_W-1:0]   generation_out,
  output logic [ghlt_pkg::KIND_W-1:0] kind_out
);
  import ghlt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_OSCAN, S_LREAD, S_LCHK, S_LMATCH, S_LFREE, S_KILL
  } state_t;

  state_t st;
  cmd_t   cmd_q;
  ident_t id_q, key;
  logic   fam_q;
  logic [ID_W-1:0]   req_q;
  logic [LGEN_W-1:0] hgen_q;
  logic [OBJ_CW-1:0] ocount, oiss;
  logic [PT_W-1:0]   ptotal;
  logic              opv;
  logic [OBJ_AW-1:0] opidx;
  logic [LS_CW-1:0]  liss;
  logic              lpv, lvrd, anyexh;
  logic [LS_AW-1:0]  lpidx;
  logic [LEASE_SLOTS-1:0] live, exh, lvalid;
  logic              owe, lwe;
  logic [OBJ_AW-1:0] owaddr;
  logic [LS_AW-1:0]  lwaddr;
  ident_t            owdata, orq;
  lease_entry_t      lwdata, lram_q, lrd;
  logic [OBJ_AW-1:0] ora;
  logic [LS_AW-1:0]  lra;
  res_t              res;
  logic              omatch, lmatch;
  ident_t            gen1_id, inc_id;
  logic [LGEN_W-1:0] ngen;

  assign ora = oiss[OBJ_AW-1:0];
  assign lra = liss[LS_AW-1:0];
  assign lrd = lvrd ? lram_q : '0;

  ghlt_ram #(.W($bits(ident_t)), .D(OBJECT_SLOTS), .AW(OBJ_AW)) u_obj (
    .clk(clk), .we(owe), .waddr(owaddr), .wdata(owdata), .raddr(ora), .rdata(orq)
  );

  ghlt_ram #(.W($bits(lease_entry_t)), .D(LEASE_SLOTS), .AW(LS_AW)) u_lease (
    .clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata), .raddr(lra), .rdata(lram_q)
  );

  always_comb begin
    if (cmd_q == CMD_REGISTER) begin
      omatch = orq.proj == key.proj && orq.obj == key.obj && orq.kind == key.kind;
    end else begin
      omatch = orq == key;
    end
    lmatch  = live[lpidx] && lrd.target == id_q;
    gen1_id = '{proj: id_q.proj, obj: id_q.obj, gen: ID_W'(1), kind: id_q.kind};
    inc_id  = '{proj: id_q.proj, obj: id_q.obj, gen: id_q.gen + ID_W'(1), kind: id_q.kind};
    ngen    = lrd.lgen + LGEN_W'(1);
  end

  assign busy           = (st != S_IDLE);
  assign ok             = res.ok;
  assign status         = res.status;
  assign handle_out     = res.handle;
  assign proj_num_out   = res.id.proj;
  assign obj_num_out    = res.id.obj;
  assign generation_out = res.id.gen;
  assign kind_out       = res.id.kind;

  always_ff @(posedge clk) begin
    lvrd <= lvalid[lra];
    owe  <= 1'b0;
    lwe  <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      st     <= S_IDLE;
      ocount <= '0;
      ptotal <= '0;
      live   <= '0;
      exh    <= '0;
      lvalid <= '0;
      opv    <= 1'b0;
      lpv    <= 1'b0;
      res    <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (start) begin
            cmd_q  <= cmd_t'(cmd);
            id_q   <= '{proj: proj_num, obj: obj_num, gen: generation, kind: object_kind};
            key    <= '{proj: proj_num, obj: obj_num, gen: generation, kind: object_kind};
            fam_q  <= kind_group;
            req_q  <= required_project;
            hgen_q <= handle[HDL_W-1:TAG_W+SLOT_W];
            oiss   <= '0;
            opv    <= 1'b0;
            liss   <= '0;
            lpv    <= 1'b0;
            anyexh <= 1'b0;
            unique case (cmd_t'(cmd))
              CMD_REGISTER: begin
                if (object_kind == KIND_NONE || proj_num == '0 || obj_num == '0) begin
                  res <= mk_res(ST_BAD, '0, '0); done <= 1'b1;
                end else if (ocount >= OBJ_CW'(OBJECT_SLOTS) ||
                             (object_kind == KIND_PROJECT &&
                              ptotal >= PT_W'(PROJECT_LIMIT))) begin
                  res <= mk_res(ST_FULL, '0, '0); done <= 1'b1;
                end else begin
                  st <= S_OSCAN;
                end
              end
              CMD_RESOLVE: begin
                if (!kind_group && object_kind == KIND_NONE) begin
                  res <= mk_res(ST_BAD, '0, '0); done <= 1'b1;
                end else if (handle[TAG_W-1:0] != TAG_VALUE ||
                             {1'b0, handle[TAG_W+SLOT_W-1:TAG_W]} >=
                             (SLOT_W+1)'(LEASE_SLOTS) ||
                             handle[HDL_W-1:TAG_W+SLOT_W] == '0) begin
                  res <= mk_res(ST_STALE, '0, '0); done <= 1'b1;
                end else begin
                  liss <= LS_CW'(handle[TAG_W+SLOT_W-1:TAG_W]);
                  st   <= S_LREAD;
                end
              end
              default: st <= S_OSCAN;
            endcase
          end
        end
        S_LREAD: begin
          lpidx <= lra;
          st    <= S_LCHK;
        end
        S_LCHK: begin
          if (live[lpidx] && lrd.lgen == hgen_q) begin
            key <= lrd.target;
            st  <= S_OSCAN;
          end else begin
            res <= mk_res(ST_STALE, '0, '0); done <= 1'b1; st <= S_IDLE;
          end
        end
        S_OSCAN: begin
          if (oiss < ocount) begin
            oiss  <= oiss + OBJ_CW'(1);
            opv   <= 1'b1;
            opidx <= ora;
          end else begin
            opv <= 1'b0;
          end
          if ((opv && omatch) || (!opv && oiss == ocount)) begin
            opv  <= 1'b0;
            liss <= '0;
            lpv  <= 1'b0;
            unique case (cmd_q)
              CMD_REGISTER: begin
                st <= S_IDLE; done <= 1'b1;
                if (opv) begin
                  res <= mk_res(ST_BAD, '0, '0);
                end else begin
                  owe    <= 1'b1;
                  owaddr <= ocount[OBJ_AW-1:0];
                  owdata <= gen1_id;
                  ocount <= ocount + OBJ_CW'(1);
                  if (id_q.kind == KIND_PROJECT) begin
                    ptotal <= ptotal + PT_W'(1);
                  end
                  res <= mk_res(ST_OK, '0, gen1_id);
                end
              end
              CMD_BORROW: begin
                if (opv) begin
                  st <= S_LMATCH;
                end else begin
                  res <= mk_res(ST_STALE, '0, '0); done <= 1'b1; st <= S_IDLE;
                end
              end
              CMD_RESOLVE: begin
                st <= S_IDLE; done <= 1'b1;
                if (!opv) begin
                  res <= mk_res(ST_STALE, '0, '0);
                end else if ((fam_q ? !is_item_group(orq.kind) : orq.kind != id_q.kind) ||
                             (req_q != '0 && orq.proj != req_q)) begin
                  res <= mk_res(ST_MISMATCH, '0, '0);
                end else begin
                  res <= mk_res(ST_OK, '0, orq);
                end
              end
              default: begin
                if (!opv) begin
                  res <= mk_res(ST_STALE, '0, '0); done <= 1'b1; st <= S_IDLE;
                end else if (id_q.gen == GEN_MAX) begin
                  res <= mk_res(ST_EXHAUSTED, '0, '0); done <= 1'b1; st <= S_IDLE;
                end else begin
                  owaddr <= opidx;
                  st     <= S_KILL;
                end
              end
            endcase
          end
        end
        S_LMATCH, S_LFREE, S_KILL: begin
          if (liss < LS_CW'(LEASE_SLOTS)) begin
            liss  <= liss + LS_CW'(1);
            lpv   <= 1'b1;
            lpidx <= lra;
          end else begin
            lpv <= 1'b0;
          end
          if (st == S_LMATCH) begin
            if (lpv && lmatch) begin
              res <= mk_res(ST_OK, {lrd.lgen, SLOT_W'(lpidx), TAG_VALUE}, id_q);
              done <= 1'b1; st <= S_IDLE;
            end else if (!lpv && liss == LS_CW'(LEASE_SLOTS)) begin
              liss <= '0;
              st   <= S_LFREE;
            end
          end else if (st == S_LFREE) begin
            if (lpv && !live[lpidx]) begin
              if (exh[lpidx]) begin
                anyexh <= 1'b1;
              end else if (lrd.lgen >= LEASE_GEN_MAX) begin
                exh[lpidx] <= 1'b1;
                anyexh     <= 1'b1;
              end else begin
                lwe           <= 1'b1;
                lwaddr        <= lpidx;
                lwdata        <= '{lgen: ngen, target: id_q};
                live[lpidx]   <= 1'b1;
                lvalid[lpidx] <= 1'b1;
                res  <= mk_res(ST_OK, {ngen, SLOT_W'(lpidx), TAG_VALUE}, id_q);
                done <= 1'b1; st <= S_IDLE;
              end
            end else if (!lpv && liss == LS_CW'(LEASE_SLOTS)) begin
              res  <= mk_res(anyexh ? ST_EXHAUSTED : ST_FULL, '0, '0);
              done <= 1'b1; st <= S_IDLE;
            end
          end else begin
            if (lpv && lmatch) begin
              live[lpidx] <= 1'b0;
            end
            if (!lpv && liss == LS_CW'(LEASE_SLOTS)) begin
              owe    <= 1'b1;
              owdata <= inc_id;
              res    <= mk_res(ST_OK, '0, inc_id);
              done   <= 1'b1; st <= S_IDLE;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/ghlt_ram.sv =====
// Generic single-port-write, registered-read memory.
`default_nettype none
module ghlt_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== tb/tb_generational_handle_lease_table.sv =====
// Self-checking testbench for the generational handle lease table.
`timescale 1ns / 100ps
`default_nettype none
module tb_generational_handle_lease_table;
  import ghlt_pkg::*;

  typedef struct {
    cmd_t              cmd;
    logic [ID_W-1:0]   proj;
    logic [ID_W-1:0]   obj;
    logic [ID_W-1:0]   gen;
    logic [KIND_W-1:0] kind;
    logic [HDL_W-1:0]  hdl;
    logic              fam;
    logic [ID_W-1:0]   need_proj;
  } request_t;

  class lease_scoreboard;
    ident_t            objects[OBJECT_SLOTS];
    int unsigned       n_objects;
    int unsigned       n_projects;
    bit                live[LEASE_SLOTS];
    bit                spent[LEASE_SLOTS];
    logic [LGEN_W-1:0] lgen[LEASE_SLOTS];
    ident_t            target[LEASE_SLOTS];
    res_t              awaited[$];
    int unsigned       errors;

    function new();
      n_objects = 0;
      n_projects = 0;
      errors = 0;
      for (int i = 0; i < LEASE_SLOTS; i++) begin
        live[i] = 0;
        spent[i] = 0;
        lgen[i] = '0;
        target[i] = '0;
      end
    endfunction

    function int find(ident_t id);
      for (int i = 0; i < n_objects; i++)
        if (objects[i] == id) return i;
      return -1;
    endfunction

    function void note(request_t r);
      res_t              e;
      ident_t            id;
      ident_t            hit;
      logic [ST_W-1:0]   st;
      logic [HDL_W-1:0]  h;
      logic [SLOT_W-1:0] slot;
      logic [LGEN_W-1:0] lg;
      logic [KIND_W-1:0] k;
      int                idx;
      bit                fin;
      bit                any_spent;
      bit                kind_bad;
      id.proj = r.proj;
      id.obj = r.obj;
      id.gen = r.gen;
      id.kind = r.kind;
      st = ST_OK;
      h = '0;
      hit = '0;
      fin = 0;
      any_spent = 0;
      case (r.cmd)
        CMD_REGISTER: begin
          if (id.kind == KIND_NONE || id.proj == 0 || id.obj == 0) begin
            st = ST_BAD;
          end else if (n_objects >= OBJECT_SLOTS ||
                       (id.kind == KIND_PROJECT && n_projects >= PROJECT_LIMIT)) begin
            st = ST_FULL;
          end else begin
            for (int i = 0; i < n_objects; i++)
              if (objects[i].proj == id.proj && objects[i].obj == id.obj &&
                  objects[i].kind == id.kind) st = ST_BAD;
            if (st == ST_OK) begin
              id.gen = 1;
              objects[n_objects] = id;
              n_objects++;
              if (id.kind == KIND_PROJECT) n_projects++;
              hit = id;
            end
          end
        end
        CMD_BORROW: begin
          if (find(id) < 0) begin
            st = ST_STALE;
          end else begin
            for (int i = 0; i < LEASE_SLOTS && !fin; i++)
              if (live[i] && target[i] == id) begin
                h = {lgen[i], SLOT_W'(i), TAG_VALUE};
                fin = 1;
              end
            for (int i = 0; i < LEASE_SLOTS && !fin; i++) begin
              if (live[i]) continue;
              if (spent[i]) begin
                any_spent = 1;
                continue;
              end
              if (lgen[i] >= LEASE_GEN_MAX) begin
                spent[i] = 1;
                any_spent = 1;
                continue;
              end
              lgen[i]++;
              target[i] = id;
              live[i] = 1;
              h = {lgen[i], SLOT_W'(i), TAG_VALUE};
              fin = 1;
            end
            if (fin) hit = id;
            else st = any_spent ? ST_EXHAUSTED : ST_FULL;
          end
        end
        CMD_RESOLVE: begin
          slot = r.hdl[11:4];
          lg = r.hdl[42:12];
          if (!r.fam && r.kind == KIND_NONE) begin
            st = ST_BAD;
          end else if (r.hdl[3:0] != TAG_VALUE || slot >= LEASE_SLOTS || lg == 0 ||
                       !live[slot] || lgen[slot] != lg) begin
            st = ST_STALE;
          end else begin
            idx = find(target[slot]);
            if (idx < 0) begin
              st = ST_STALE;
            end else begin
              k = objects[idx].kind;
              kind_bad = r.fam ? !(k == KIND_ITEM || k == KIND_FOLDER || k == KIND_FOOTAGE)
                               : (k != r.kind);
              if (kind_bad || (r.need_proj != 0 && objects[idx].proj != r.need_proj))
                st = ST_MISMATCH;
              else
                hit = objects[idx];
            end
          end
        end
        default: begin
          idx = find(id);
          if (idx < 0) begin
            st = ST_STALE;
          end else if (id.gen == GEN_MAX) begin
            st = ST_EXHAUSTED;
          end else begin
            for (int i = 0; i < LEASE_SLOTS; i++)
              if (live[i] && target[i] == id) live[i] = 0;
            objects[idx].gen++;
            hit = objects[idx];
          end
        end
      endcase
      e.ok = (st == ST_OK);
      e.status = st;
      e.handle = h;
      e.id = hit;
      awaited.push_back(e);
    endfunction

    function void check(res_t got);
      res_t e;
      if (awaited.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.ok !== e.ok) begin
        $error("ok: expected %0d, got %0d", e.ok, got.ok);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.handle !== e.handle) begin
        $error("handle_out: expected %h, got %h", e.handle, got.handle);
        errors++;
      end
      if (got.id.proj !== e.id.proj) begin
        $error("proj_num_out: expected %h, got %h", e.id.proj, got.id.proj);
        errors++;
      end
      if (got.id.obj !== e.id.obj) begin
        $error("obj_num_out: expected %h, got %h", e.id.obj, got.id.obj);
        errors++;
      end
      if (got.id.gen !== e.id.gen) begin
        $error("generation_out: expected %h, got %h", e.id.gen, got.id.gen);
        errors++;
      end
      if (got.id.kind !== e.id.kind) begin
        $error("kind_out: expected %0d, got %0d", e.id.kind, got.id.kind);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  logic              busy;
  logic              done;
  logic              ok;
  logic [ST_W-1:0]   status;
  logic [HDL_W-1:0]  handle_out;
  logic [ID_W-1:0]   proj_num_out;
  logic [ID_W-1:0]   obj_num_out;
  logic [ID_W-1:0]   generation_out;
  logic [KIND_W-1:0] kind_out;
  request_t          cur = '{CMD_REGISTER, 0, 0, 0, 0, 0, 0, 0};
  lease_scoreboard   sb = new();
  logic [HDL_W-1:0]  issued[$];
  ident_t            issued_id[$];

  generational_handle_lease_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cur.cmd), .proj_num(cur.proj), .obj_num(cur.obj), .generation(cur.gen),
    .object_kind(cur.kind), .handle(cur.hdl), .kind_group(cur.fam),
    .required_project(cur.need_proj), .done(done), .ok(ok), .status(status),
    .handle_out(handle_out), .proj_num_out(proj_num_out),
    .obj_num_out(obj_num_out), .generation_out(generation_out), .kind_out(kind_out)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check('{ok, status, handle_out,
                 '{proj_num_out, obj_num_out, generation_out, kind_out}});
      if (ok && handle_out != 0 && issued.size() < 64) begin
        issued.push_back(handle_out);
        issued_id.push_back('{proj_num_out, obj_num_out, generation_out, kind_out});
      end
    end
    if (!rst && start && !busy) sb.note(cur);
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  task automatic send(request_t r);
    cur = r;
    start = 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 0;
  endtask

  task automatic hold(int pct);
    if ($urandom_range(0, 99) < pct) repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  task automatic drain();
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return '1;
      2, 3, 4, 5, 6, 7: return $urandom_range(1, 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t mk(cmd_t c, logic [ID_W-1:0] p, logic [ID_W-1:0] o,
                                  logic [ID_W-1:0] g, logic [KIND_W-1:0] k);
    request_t r;
    r.cmd = c;
    r.proj = p;
    r.obj = o;
    r.gen = g;
    r.kind = k;
    r.hdl = HDL_W'({$urandom, $urandom});
    r.fam = 1'($urandom);
    r.need_proj = $urandom;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    ident_t   id;
    int       sel;
    int       roll;
    roll = $urandom_range(0, 99);
    r = mk(CMD_REGISTER, pick_id(), pick_id(), $urandom, KIND_W'($urandom_range(0, 6)));
    if (sb.n_objects > 0) begin
      id = sb.objects[$urandom_range(0, sb.n_objects - 1)];
      if ($urandom_range(0, 9) == 0) id.gen = id.gen - 1;
      else if ($urandom_range(0, 19) == 0) id.kind = KIND_W'($urandom_range(0, 6));
    end else begin
      id = '{pick_id(), pick_id(), $urandom, KIND_W'($urandom_range(0, 6))};
    end
    if (roll < 20) begin
      return r;
    end else if (roll < 50) begin
      r.cmd = CMD_BORROW;
    end else if (roll < 85) begin
      r.cmd = CMD_RESOLVE;
      r.kind = KIND_W'($urandom_range(0, 6));
      if (issued.size() > 0 && $urandom_range(0, 9) < 8) begin
        sel = $urandom_range(0, issued.size() - 1);
        r.hdl = issued[sel];
        if ($urandom_range(0, 9) < 6) r.kind = issued_id[sel].kind;
        case ($urandom_range(0, 3))
          0: r.need_proj = 0;
          1, 2: r.need_proj = issued_id[sel].proj;
          default: r.need_proj = pick_id();
        endcase
        if ($urandom_range(0, 9) == 0) r.hdl[$urandom_range(0, HDL_W - 1)] ^= 1'b1;
      end
      return r;
    end else begin
      r.cmd = CMD_INVALIDATE;
    end
    if ($urandom_range(0, 9) < 9) begin
      r.proj = id.proj;
      r.obj = id.obj;
      r.gen = id.gen;
      r.kind = id.kind;
    end
    return r;
  endfunction

  initial begin
    request_t r;
    int       pct;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    @(negedge clk);

    send(mk(CMD_REGISTER, 5, 7, 0, KIND_NONE));
    send(mk(CMD_REGISTER, 0, 7, 0, KIND_ITEM));
    send(mk(CMD_REGISTER, 5, 0, 0, KIND_ITEM));
    send(mk(CMD_REGISTER, '1, '1, '1, KIND_PROJECT));
    send(mk(CMD_REGISTER, '1, '1, 0, KIND_PROJECT));
    send(mk(CMD_REGISTER, 5, 7, 0, KIND_ITEM));
    for (int k = 3; k <= 6; k++) send(mk(CMD_REGISTER, 5, k, 0, KIND_W'(k)));
    for (int p = 1; p <= 4; p++) send(mk(CMD_REGISTER, p, 1, 0, KIND_PROJECT));
    send(mk(CMD_BORROW, 9, 9, 1, KIND_ITEM));
    send(mk(CMD_BORROW, 5, 7, 1, KIND_ITEM));
    send(mk(CMD_BORROW, 5, 7, 1, KIND_ITEM));
    r = mk(CMD_RESOLVE, 0, 0, 0, KIND_NONE);
    r.fam = 0;
    r.hdl = {31'd1, 8'd0, TAG_VALUE};
    send(r);
    r.kind = KIND_ITEM;
    r.need_proj = 0;
    send(r);
    r.need_proj = 6;
    send(r);
    r.need_proj = 5;
    r.kind = KIND_FOLDER;
    send(r);
    r.fam = 1;
    r.kind = KIND_NONE;
    send(r);
    r.hdl = {31'd1, 8'd0, 4'hB};
    send(r);
    r.hdl = {31'd1, 8'd200, TAG_VALUE};
    send(r);
    r.hdl = {31'd0, 8'd0, TAG_VALUE};
    send(r);
    send(mk(CMD_INVALIDATE, 5, 7, 1, KIND_ITEM));
    send(mk(CMD_INVALIDATE, 5, 7, 1, KIND_ITEM));
    r.hdl = {31'd1, 8'd0, TAG_VALUE};
    send(r);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: pct = 71;
        3: pct = 33;
        default: pct = 0;
      endcase
      for (int n = 0; n < 150; n++) begin
        hold(pct);
        send(random_request());
      end
      drain();
    end

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
sv/ghlt_pkg.sv
sv/ghlt_ram.sv
sv/generational_handle_lease_table.sv
tb/tb_generational_handle_lease_table.sv
